/* src/hpg_pkg.sv */
// ----------------------------------------------------------------------------
// Harmonograph point generator package
// Fixed-point constants, register indexes and the quarter-wave sine builder.
// ----------------------------------------------------------------------------
package hpg_pkg;

  localparam int INDEX_BITS_DEF      = 16;
  localparam int TRIG_TABLE_BITS_DEF = 10;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 56;
  localparam int CFG_W  = 48;
  localparam int ADDR_W = 3;

  localparam logic [30:0] Q30_ONE       = 31'd1073741824;
  localparam logic [29:0] INV_TAU_Q32   = 30'd683565276;
  localparam logic [30:0] LOG2E_Q30     = 31'd1549082005;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam logic [28:0] AMP_Q30       = 29'd483183821;
  localparam logic [30:0] BIAS_Q30      = 31'd590558003;
  localparam logic [23:0] OFF_GREEN_Q24 = 24'd5536481;
  localparam logic [23:0] OFF_BLUE_Q24  = 24'd11240735;
  localparam logic [23:0] QUARTER_Q24   = 24'd4194304;

  localparam logic [47:0] PX1_RST = 48'd35184372090012;
  localparam logic [47:0] PX2_RST = 48'd35361324728975;
  localparam logic [47:0] PY1_RST = 48'd52776987657110;
  localparam logic [47:0] PY2_RST = 48'd53130033956258;
  localparam logic [23:0] TSTEP_RST = 24'd279667;
  localparam logic [23:0] RSTEP_RST = 24'd2797;

  typedef enum logic [ADDR_W-1:0] {
    REG_PX1   = 3'd0,
    REG_PX2   = 3'd1,
    REG_PY1   = 3'd2,
    REG_PY2   = 3'd3,
    REG_TSTEP = 3'd4,
    REG_RSTEP = 3'd5
  } reg_idx_t;

  // Quarter-wave sine magnitude at step r of 2^tb, Q30, odd polynomial to x^9
  function automatic logic [30:0] sine_q30(input int unsigned r, input int tb);
    longint unsigned x, x2, h, s;
    x  = longint'(r) << (32 - tb);
    x2 = (x * x) >> 30;
    h  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    h  = 64'd85569306 - ((x2 * h) >> 30);
    h  = 64'd693598669 - ((x2 * h) >> 30);
    h  = 64'd1686629713 - ((x2 * h) >> 30);
    s  = (x * h) >> 30;
    if (s > 64'(Q30_ONE)) s = 64'(Q30_ONE);
    return s[30:0];
  endfunction

endpackage

/* src/harmonograph_point_generator.sv */
// ----------------------------------------------------------------------------
// Harmonograph point generator
// Sample index in, one saturated Q1.15 curve point and a Q0.8 colour out.
// ----------------------------------------------------------------------------
//  channel | beat fields (lowest bit first)                 | handshake
//  in_     | sample_index[15:0]                             | tvalid/tready
//  out_    | pos_x, pos_y, color_red, color_green, color_blue | tvalid/tready
//  cfg_    | register index, write data                     | write enable
//
// 25 register stages, one beat per cycle while the output accepts beats.
// The depth is set by the exp series: a multiply and a constant divide
// stage for each of its eight terms, per pendulum lane.
// Each stage holds its beat while the next is full, so a stall on the
// output loses nothing and bubbles close up. Reset clears valids and
// loads the register defaults.
module harmonograph_point_generator #(
  parameter int INDEX_BITS      = hpg_pkg::INDEX_BITS_DEF,
  parameter int TRIG_TABLE_BITS = hpg_pkg::TRIG_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hpg_pkg::IN_W-1:0]    in_tdata,   // sample_index
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hpg_pkg::OUT_W-1:0]   out_tdata,  // pos_x, pos_y, red, green, blue
  input  logic                        cfg_wen,
  input  logic [hpg_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [hpg_pkg::CFG_W-1:0]   cfg_wdata
);
  import hpg_pkg::*;

  localparam int NS      = 25;
  localparam int TB      = TRIG_TABLE_BITS;
  localparam int QUARTER = 1 << (TB - 2);
  localparam int IDX_W   = INDEX_BITS;

  // configuration
  logic [47:0] pend_r [4];
  logic [23:0] tstep_r, rstep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r[0] <= PX1_RST;
      pend_r[1] <= PX2_RST;
      pend_r[2] <= PY1_RST;
      pend_r[3] <= PY2_RST;
      tstep_r   <= TSTEP_RST;
      rstep_r   <= RSTEP_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_PX1:   pend_r[0] <= cfg_wdata;
        REG_PX2:   pend_r[1] <= cfg_wdata;
        REG_PY1:   pend_r[2] <= cfg_wdata;
        REG_PY2:   pend_r[3] <= cfg_wdata;
        REG_TSTEP: tstep_r   <= cfg_wdata[23:0];
        REG_RSTEP: rstep_r   <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // quarter-wave table
  logic [30:0] sin_tbl [QUARTER+1];
  for (genvar g = 0; g <= QUARTER; g++) begin : g_tbl
    localparam logic [30:0] V = sine_q30(g, TB);
    assign sin_tbl[g] = V;
  end

  // valid chain and per-stage advance
  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) rdy[i] = !v_r[i] || rdy[i+1];
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < NS; i++) if (rdy[i]) v_r[i] <= v_r[i-1];
    end
  end

  // stage 0: index
  logic [IDX_W-1:0] idx_r;
  always_ff @(posedge clk) if (rdy[0]) idx_r <= IDX_W'(in_tdata);

  // stage 1: time and colour position
  logic [31:0] t_r;
  logic [23:0] u_r;
  logic [55:0] tprod, uprod;
  assign tprod = 56'(idx_r) * 56'(tstep_r);
  assign uprod = 56'(idx_r) * 56'(rstep_r);
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      t_r <= (tprod[55:32] != '0) ? 32'hFFFF_FFFF : tprod[31:0];
      u_r <= uprod[23:0];
    end
  end

  // pendulum lanes: 0,1 feed x; 2,3 feed y
  logic [48:0]       angle_r [4];
  logic [47:0]       z_r     [4];
  logic [51:0]       turns_r [4];
  logic [29:0]       wf_r    [4];
  logic              big_a   [4][3:20];
  logic [4:0]        n_a     [4][3:20];
  logic [30:0]       s_a     [4][4:21];
  logic              neg_a   [4][4:22];
  logic [30:0]       term_a  [4][4:20];
  logic [29:0]       y_a     [4][4:20];
  logic [31:0]       even_a  [4][4:20];
  logic [31:0]       odd_a   [4][4:20];
  logic [30:0]       e_r     [4];
  logic [30:0]       m1_r    [4];
  logic signed [15:0] pt_r   [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [62:0]   turns_full, w_full;
    logic [59:0]   y_full;
    logic [52:0]   sidx_sum;
    logic [TB-1:0] six;
    logic [TB-2:0] sr;
    logic [31:0]   ediff;
    logic [61:0]   m1_full;
    logic [59:0]   m2_full;
    logic [14:0]   mag;

    assign turns_full = 63'(angle_r[l][48:16]) * 63'(INV_TAU_Q32);
    assign w_full     = 63'(z_r[l][47:16]) * 63'(LOG2E_Q30);
    assign y_full     = 60'(wf_r[l]) * 60'(LN2_Q30);
    assign sidx_sum   = {1'b0, turns_r[l]} + (53'(1) << (51 - TB));
    assign six        = sidx_sum[51 -: TB];
    assign sr = six[TB-2] ? (TB-1)'(QUARTER) - {1'b0, six[TB-3:0]} : {1'b0, six[TB-3:0]};
    assign ediff = (even_a[l][20] > odd_a[l][20]) ? even_a[l][20] - odd_a[l][20] : '0;
    assign m1_full = 62'(s_a[l][21]) * 62'(e_r[l]);
    assign m2_full = 60'(m1_r[l]) * 60'(AMP_Q30);
    assign mag     = 15'((m2_full[59:30] + 30'(1 << 14)) >> 15);

    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        angle_r[l] <= 49'(pend_r[l][47:32]) * 49'(t_r) + {10'd0, pend_r[l][31:16], 23'd0};
        z_r[l]     <= 48'(pend_r[l][15:0]) * 48'(t_r);
      end
      if (rdy[3]) begin
        turns_r[l]   <= turns_full[51:0];
        big_a[l][3]  <= (w_full[62:54] >= 9'd31);
        n_a[l][3]    <= w_full[58:54];
        wf_r[l]      <= w_full[53:24];
      end
      if (rdy[4]) begin
        s_a[l][4]    <= sin_tbl[sr];
        neg_a[l][4]  <= six[TB-1];
        big_a[l][4]  <= big_a[l][3];
        n_a[l][4]    <= n_a[l][3];
        y_a[l][4]    <= y_full[59:30];
        term_a[l][4] <= Q30_ONE;
        even_a[l][4] <= 32'(Q30_ONE);
        odd_a[l][4]  <= '0;
      end
      for (int i = 5; i <= 21; i++) if (rdy[i]) s_a[l][i] <= s_a[l][i-1];
      for (int i = 5; i <= 20; i++) begin
        if (rdy[i]) begin
          big_a[l][i] <= big_a[l][i-1];
          n_a[l][i]   <= n_a[l][i-1];
        end
      end
      for (int i = 5; i <= 22; i++) if (rdy[i]) neg_a[l][i] <= neg_a[l][i-1];
      if (rdy[21]) e_r[l] <= big_a[l][20] ? '0 : 31'(ediff >> n_a[l][20]);
      if (rdy[22]) m1_r[l] <= m1_full[60:30];
      if (rdy[23]) pt_r[l] <= neg_a[l][22] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // exp series: term k = term(k-1) * y / k, a multiply stage then a divide stage
    for (genvar k = 1; k <= 8; k++) begin : g_term
      localparam int P = 3 + 2 * k;
      localparam int D = 4 + 2 * k;
      logic [60:0] prod;
      logic [30:0] quo;
      assign prod = 61'(term_a[l][P-1]) * 61'(y_a[l][P-1]);
      if ((k & (k - 1)) == 0) begin : g_shift
        assign quo = term_a[l][D-1] >> $clog2(k);
      end else begin : g_recip
        localparam logic [32:0] RECIP = 33'((64'd1 << 34) / k + 1);
        logic [63:0] qm;
        // exact floor division for a dividend below 2^31
        assign qm  = 64'(term_a[l][D-1]) * 64'(RECIP);
        assign quo = 31'(qm >> 34);
      end
      always_ff @(posedge clk) begin
        if (rdy[P]) begin
          term_a[l][P] <= prod[60:30];
          y_a[l][P]    <= y_a[l][P-1];
          even_a[l][P] <= even_a[l][P-1];
          odd_a[l][P]  <= odd_a[l][P-1];
        end
        if (rdy[D]) begin
          term_a[l][D] <= quo;
          y_a[l][D]    <= y_a[l][D-1];
          if (k % 2 == 1) begin
            odd_a[l][D]  <= odd_a[l][D-1] + 32'(quo);
            even_a[l][D] <= even_a[l][D-1];
          end else begin
            even_a[l][D] <= even_a[l][D-1] + 32'(quo);
            odd_a[l][D]  <= odd_a[l][D-1];
          end
        end
      end
    end
  end

  // colour channels
  logic [7:0] col_a [3][4:24];
  logic [30:0] c_r  [3];
  logic        cn_a [3][2:3];
  logic [29:0] cm_r [3];
  logic [23:0] coff [3];
  assign coff[0] = QUARTER_Q24;
  assign coff[1] = OFF_GREEN_Q24 + QUARTER_Q24;
  assign coff[2] = OFF_BLUE_Q24 + QUARTER_Q24;

  for (genvar c = 0; c < 3; c++) begin : g_col
    logic [23:0]   p;
    logic [24:0]   csum;
    logic [TB-1:0] cix;
    logic [TB-2:0] cr;
    logic [59:0]   cm_full;
    logic [30:0]   cv;
    logic [8:0]    crnd;
    assign p    = u_r + coff[c];
    assign csum = {1'b0, p} + (25'(1) << (23 - TB));
    assign cix  = csum[23 -: TB];
    assign cr = cix[TB-2] ? (TB-1)'(QUARTER) - {1'b0, cix[TB-3:0]} : {1'b0, cix[TB-3:0]};
    assign cm_full = 60'(c_r[c]) * 60'(AMP_Q30);
    assign cv   = cn_a[c][3] ? BIAS_Q30 - 31'(cm_r[c]) : BIAS_Q30 + 31'(cm_r[c]);
    assign crnd = 9'((32'(cv) + 32'(1 << 21)) >> 22);
    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        c_r[c]     <= sin_tbl[cr];
        cn_a[c][2] <= cix[TB-1];
      end
      if (rdy[3]) begin
        cm_r[c]    <= cm_full[59:30];
        cn_a[c][3] <= cn_a[c][2];
      end
      if (rdy[4]) col_a[c][4] <= crnd[8] ? 8'hFF : crnd[7:0];
      for (int i = 5; i <= 24; i++) if (rdy[i]) col_a[c][i] <= col_a[c][i-1];
    end
  end

  // stage 24: axis sums with saturation
  logic signed [16:0] sx, sy;
  logic [15:0] posx_r, posy_r;
  assign sx = 17'(pt_r[0]) + 17'(pt_r[1]);
  assign sy = 17'(pt_r[2]) + 17'(pt_r[3]);

  function automatic logic [15:0] sat16(input logic signed [16:0] a);
    logic [15:0] r;
    if (a > 17'sd32767) r = 16'h7FFF;
    else if (a < -17'sd32768) r = 16'h8000;
    else r = a[15:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rdy[24]) begin
      posx_r <= sat16(sx);
      posy_r <= sat16(sy);
    end
  end

  assign out_tdata = {col_a[2][24], col_a[1][24], col_a[0][24], posy_r, posx_r};

`ifndef SYNTH
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input stalled with empty output");
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[23] |-> (pt_r[0] <= 16'sd14746 && pt_r[0] >= -16'sd14746))
    else $error("pendulum term out of range");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !v_r[23] |=> !out_tvalid)
    else $error("result repeated after drain");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Harmonograph point generator testbench
// Streams sample indexes through the generator under several register
// settings. It predicts each point and colour in fixed point, compares every
// output beat field by field, and applies random gaps and backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import hpg_pkg::*;

  localparam int IDX_W = INDEX_BITS_DEF;
  localparam int TB    = TRIG_TABLE_BITS_DEF;
  localparam int LATENCY = 25;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ADDR_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint unsigned MASK24 = 64'hFFFFFF;
  localparam longint unsigned MASK52 = 64'hF_FFFF_FFFF_FFFF;
  localparam longint unsigned MASK54 = 64'h3F_FFFF_FFFF_FFFF;
  localparam logic [IN_W-1:0] CORNER_IDX [8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000,
                                                 16'h5555, 16'hAAAA, 16'h00FF, 16'h7FFF};

  // packed from the top bit down, so blue sits highest as on out_tdata
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } point_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_W-1:0] in_tdata;   // sample_index
  logic out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata; // pos_x, pos_y, red, green, blue
  logic cfg_wen;
  logic [ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  harmonograph_point_generator dut (.*);

  longint unsigned regs [6];
  logic [IN_W-1:0] index_queue [$];
  point_t points_due [$];
  bit sender_gaps, receiver_gaps, hold_start, hold_taken;
  int errors = 0;
  int cycles = 0;
  int send_gap, recv_stall, hold_cnt;

  function automatic longint unsigned sine_mag(input longint unsigned f52, output bit neg);
    longint unsigned idx, quad, r, x, x2, h, s, quarter;
    quarter = 64'd1 << (TB - 2);
    idx = ((f52 & MASK52) + (64'd1 << (51 - TB))) >> (52 - TB);
    idx &= (64'd1 << TB) - 1;
    quad = idx >> (TB - 2);
    r = idx & (quarter - 1);
    if (quad[0]) r = quarter - r;
    neg = quad >= 2;
    x = r << (32 - TB);
    x2 = (x * x) >> 30;
    h = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    h = 64'd85569306 - ((x2 * h) >> 30);
    h = 64'd693598669 - ((x2 * h) >> 30);
    h = 64'd1686629713 - ((x2 * h) >> 30);
    s = (x * h) >> 30;
    return s > 64'(Q30_ONE) ? 64'(Q30_ONE) : s;
  endfunction

  // exp(-z), z in Q.40, result Q30
  function automatic longint unsigned decay_factor(input longint unsigned z40);
    longint unsigned w, n, y, term, even, odd;
    w = (z40 >> 16) * 64'(LOG2E_Q30);
    n = w >> 54;
    if (n >= 31) return 0;
    y = (((w & MASK54) >> 24) * 64'(LN2_Q30)) >> 30;
    term = 64'(Q30_ONE); even = 64'(Q30_ONE); odd = 0;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * y) >> 30) / k;
      if (k % 2 == 1) odd += term;
      else even += term;
    end
    return (even > odd ? even - odd : 0) >> n;
  endfunction

  function automatic int swing(input longint unsigned pend, input longint unsigned t24);
    longint unsigned freq, phase, decay, ang, s, e, m;
    bit neg;
    freq = (pend >> 32) & 64'hFFFF;
    phase = (pend >> 16) & 64'hFFFF;
    decay = pend & 64'hFFFF;
    ang = freq * t24 + (phase << 23);
    s = sine_mag((ang >> 16) * 64'(INV_TAU_Q32), neg);
    e = decay_factor(decay * t24);
    m = (((s * e) >> 30) * 64'(AMP_Q30)) >> 30;
    m = (m + (64'd1 << 14)) >> 15;
    return neg ? -int'(m) : int'(m);
  endfunction

  function automatic logic [15:0] clamp_q15(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [7:0] shade(input longint unsigned u24);
    longint unsigned c, m, v;
    bit neg;
    c = sine_mag(((u24 + 64'(QUARTER_Q24)) & MASK24) << 28, neg);
    m = (c * 64'(AMP_Q30)) >> 30;
    v = neg ? 64'(BIAS_Q30) - m : 64'(BIAS_Q30) + m;
    v = (v + (64'd1 << 21)) >> 22;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic point_t plot_point(input logic [IN_W-1:0] sample);
    longint unsigned idx, t, u;
    point_t p;
    idx = 64'(sample) & ((64'd1 << IDX_W) - 1);
    t = idx * regs[REG_TSTEP];
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;  // long time saturates
    p.pos_x = clamp_q15(swing(regs[REG_PX1], t) + swing(regs[REG_PX2], t));
    p.pos_y = clamp_q15(swing(regs[REG_PY1], t) + swing(regs[REG_PY2], t));
    u = (idx * regs[REG_RSTEP]) & MASK24;
    p.red = shade(u);
    p.green = shade((u + 64'(OFF_GREEN_Q24)) & MASK24);
    p.blue = shade((u + 64'(OFF_BLUE_Q24)) & MASK24);
    return p;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("harmonograph_point_generator: mismatch");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) points_due.insert(points_due.size(), plot_point(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 0;
        end else if (index_queue.size() > 0) begin
          in_tdata <= index_queue.pop_front();
          in_tvalid <= 1;
          send_gap = sender_gaps ? $urandom_range(0, 14) : 0;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    point_t got, want;
    if (!rst_n) begin
      out_tready <= 0;
      recv_stall = 0;
      hold_cnt = 0;
      hold_taken = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (points_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = points_due.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
            errors++;
          end
          if (got.pos_y !== want.pos_y) begin
            $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
            errors++;
          end
          if (got.red !== want.red) begin
            $display("%0t: red expected %h actual %h", $time, want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %h actual %h", $time, want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
            errors++;
          end
        end
        recv_stall = receiver_gaps ? $urandom_range(0, 14) : 0;
      end
      if (hold_start && !hold_taken) begin
        hold_taken = 1;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic write_reg(input logic [ADDR_W-1:0] a, input longint unsigned d);
    @(posedge clk);
    cfg_wen <= 1;
    cfg_addr <= a;
    cfg_wdata <= d[CFG_W-1:0];
    if (a <= REG_RSTEP) regs[a] = (a >= REG_TSTEP) ? (d & MASK24) : (d & 64'hFFFF_FFFF_FFFF);
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  // checked between edges so that the sender's updates have settled
  task automatic drain();
    while (!(index_queue.size() == 0 && !in_tvalid && points_due.size() == 0))
      @(negedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic queue_index(input logic [IN_W-1:0] s);
    index_queue.insert(index_queue.size(), s);
  endtask

  task automatic queue_corners();
    for (int i = 0; i < 8; i++) queue_index(CORNER_IDX[i]);
  endtask

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++)
      queue_index(IN_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 65535)));
  endtask

  function automatic longint unsigned rand48();
    return {$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF;
  endfunction

  initial begin
    rst_n = 0;
    cfg_wen = 0; cfg_addr = '0; cfg_wdata = '0;
    sender_gaps = 1; receiver_gaps = 1; hold_start = 0;
    regs[REG_PX1] = PX1_RST; regs[REG_PX2] = PX2_RST;
    regs[REG_PY1] = PY1_RST; regs[REG_PY2] = PY2_RST;
    regs[REG_TSTEP] = TSTEP_RST; regs[REG_RSTEP] = RSTEP_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // reset settings: directed edges, long time saturates at the top indexes
    queue_corners();
    for (int i = 0; i < 16; i++) queue_index(IN_W'(1 << i));
    drain();
    random_burst(120);
    drain();

    // writes to the spare indexes must change nothing
    write_reg(REG_SPARE_LO, rand48());
    write_reg(REG_SPARE_HI, rand48());
    random_burst(60);
    drain();

    // all zero: no swing, time frozen, colour fixed with the red channel at full
    for (int r = REG_PX1; r <= REG_RSTEP; r++) write_reg(r[ADDR_W-1:0], 0);
    queue_corners();
    random_burst(40);
    drain();

    // all ones
    for (int r = REG_PX1; r <= REG_RSTEP; r++) write_reg(r[ADDR_W-1:0], 64'hFFFF_FFFF_FFFF);
    queue_corners();
    random_burst(80);
    drain();

    // undamped, in phase: both terms add up
    write_reg(REG_PX1, 48'h1000_3244_0000);
    write_reg(REG_PX2, 48'h1000_3244_0000);
    write_reg(REG_PY1, 48'h2000_0000_0000);
    write_reg(REG_PY2, 48'h2000_0000_0000);
    write_reg(REG_TSTEP, 24'h000400);
    write_reg(REG_RSTEP, 24'h010000);
    random_burst(100);
    drain();

    // long hold-off on the output while the input keeps coming
    sender_gaps = 0; receiver_gaps = 0;
    hold_start = 1;
    random_burst(120);
    drain();
    sender_gaps = 1; receiver_gaps = 1;

    for (int ph = 0; ph < 6; ph++) begin
      for (int r = REG_PX1; r <= REG_RSTEP; r++)
        write_reg(r[ADDR_W-1:0], r >= REG_TSTEP && ph % 2 == 0 ?
                                 $urandom_range(0, 4095) : rand48());
      sender_gaps = ph != 2;
      receiver_gaps = ph != 3;
      random_burst(80);
      drain();
    end

    if (errors == 0) $display("harmonograph_point_generator: match");
    else $display("harmonograph_point_generator: mismatch");
    $finish;
  end

endmodule
